[rtl/min_stk_pkg.sv]
// ---------------------------------------------------------------------------
// min_stk_pkg
// Shared sizes, codes and state type for the minimum-tracking stack.
// ---------------------------------------------------------------------------
package min_stk_pkg;

    // store geometry
    localparam int DEPTH  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 6;
    localparam int DATA_W = 32;

    // operation codes (the unused code behaves as a query)
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_OVER  = 2'd1;
    localparam logic [1:0] STAT_UNDER = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH_MIN,
        ST_POP_WAIT
    } t_state;

endpackage

[rtl/min_tracking_stack.sv]
// ---------------------------------------------------------------------------
// min_tracking_stack
// LIFO stack of signed words that reports its minimum with every beat. One
// synchronous store holds the main stack (growing up from entry 0) and the
// minimum stack (growing down from entry capacity-1).
// ---------------------------------------------------------------------------
//  channel   | signals                                   | handshake
//  ----------+-------------------------------------------+---------------------
//  command   | i_operation, i_value                      | start && !busy
//  result    | o_status, o_popped_value, o_top_value,    | o_valid, one cycle
//            | o_min_value, o_is_empty                   |
//  config    | i_cfg_data                                | i_cfg_we
//
//  steps: query, rejected push, underflow pop and a push that stays off the
//    minimum stack finish on acceptance; a push onto both stacks also takes
//    ST_PUSH_MIN (single write port); ST_POP_WAIT reads the new top and minimum.
//  result appears the cycle after the command's last cycle of work.
//  reset: synchronous, active low; capacity 32, both stacks empty, no
//    clearing pass. A capacity write also empties both stacks.
//  the receiver cannot stall; a new command may be taken while a result shows.
// ---------------------------------------------------------------------------
module min_tracking_stack (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_operation,
    input  logic signed [min_stk_pkg::DATA_W-1:0] i_value,
    input  logic                                 i_cfg_we,
    input  logic [min_stk_pkg::CAP_W-1:0]        i_cfg_data,
    output logic                                 o_valid,
    output logic [1:0]                           o_status,
    output logic signed [min_stk_pkg::DATA_W-1:0] o_popped_value,
    output logic signed [min_stk_pkg::DATA_W-1:0] o_top_value,
    output logic signed [min_stk_pkg::DATA_W-1:0] o_min_value,
    output logic                                 o_is_empty
);

    localparam int AW = min_stk_pkg::ADDR_W;
    localparam int CW = min_stk_pkg::CNT_W;
    localparam int DW = min_stk_pkg::DATA_W;

    // entry store
    logic signed [DW-1:0] mem [min_stk_pkg::DEPTH];

    // control and cached values
    min_stk_pkg::t_state r_state, n_state;
    logic [CW-1:0]        r_main_cnt, n_main_cnt;
    logic [CW-1:0]        r_min_cnt, n_min_cnt;
    logic [min_stk_pkg::CAP_W-1:0] r_cap;
    logic signed [DW-1:0] r_top, n_top;
    logic signed [DW-1:0] r_min, n_min;
    logic signed [DW-1:0] r_val, n_val;
    logic signed [DW-1:0] r_popped, n_popped;
    logic signed [DW-1:0] r_rd_top, r_rd_min;

    // combinational datapath
    logic [CW-1:0]        cap_eff;
    logic [CW:0]          need_sum;
    logic                 to_min;
    logic                 accept;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic signed [DW-1:0] mem_wdata;
    logic [AW-1:0]        rd_addr_top, rd_addr_min;
    logic [CW-1:0]        min_slot;
    logic                 emit;
    logic [1:0]           res_status;
    logic signed [DW-1:0] res_popped;

    assign busy   = (r_state != min_stk_pkg::ST_IDLE);
    assign accept = start && !busy;

    // effective capacity, clamped to the legal range
    always_comb begin
        if (r_cap < min_stk_pkg::CAP_W'(2)) begin
            cap_eff = CW'(2);
        end else if (int'(r_cap) > min_stk_pkg::DEPTH) begin
            cap_eff = CW'(min_stk_pkg::DEPTH);
        end else begin
            cap_eff = CW'(r_cap);
        end
    end

    // push decision: goes on the minimum stack too, and total room needed
    assign to_min   = (r_min_cnt == '0) || (i_value <= r_min);
    assign need_sum = {1'b0, r_main_cnt} + {1'b0, r_min_cnt} + (to_min ? (CW+1)'(2)
                                                                       : (CW+1)'(1));
    assign min_slot = cap_eff - r_min_cnt - CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            min_stk_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_operation == min_stk_pkg::OP_PUSH) begin
                        if (need_sum <= {1'b0, cap_eff} && to_min) begin
                            n_state = min_stk_pkg::ST_PUSH_MIN;
                        end
                    end else if (i_operation == min_stk_pkg::OP_POP) begin
                        if (r_main_cnt != '0) begin
                            n_state = min_stk_pkg::ST_POP_WAIT;
                        end
                    end
                end
            end
            min_stk_pkg::ST_PUSH_MIN: n_state = min_stk_pkg::ST_IDLE;
            min_stk_pkg::ST_POP_WAIT: n_state = min_stk_pkg::ST_IDLE;
            default:                  n_state = min_stk_pkg::ST_IDLE;
        endcase
    end

    // datapath, store access and result
    always_comb begin
        n_main_cnt = r_main_cnt;
        n_min_cnt  = r_min_cnt;
        n_top      = r_top;
        n_min      = r_min;
        n_val      = r_val;
        n_popped   = r_popped;
        mem_we     = 1'b0;
        mem_waddr  = r_main_cnt[AW-1:0];
        mem_wdata  = r_val;
        emit       = 1'b0;
        res_status = min_stk_pkg::STAT_OK;
        res_popped = '0;
        unique case (r_state)
            min_stk_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_operation)
                        min_stk_pkg::OP_PUSH: begin
                            if (need_sum > {1'b0, cap_eff}) begin
                                emit       = 1'b1;
                                res_status = min_stk_pkg::STAT_OVER;
                            end else begin
                                mem_we     = 1'b1;
                                mem_waddr  = r_main_cnt[AW-1:0];
                                mem_wdata  = i_value;
                                n_main_cnt = r_main_cnt + CW'(1);
                                n_top      = i_value;
                                n_val      = i_value;
                                emit       = !to_min;
                            end
                        end
                        min_stk_pkg::OP_POP: begin
                            if (r_main_cnt == '0) begin
                                emit       = 1'b1;
                                res_status = min_stk_pkg::STAT_UNDER;
                            end else begin
                                n_popped   = r_top;
                                n_main_cnt = r_main_cnt - CW'(1);
                                if (r_min_cnt != '0 && r_top == r_min) begin
                                    n_min_cnt = r_min_cnt - CW'(1);
                                end
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            min_stk_pkg::ST_PUSH_MIN: begin
                // second write: the same value onto the minimum stack
                mem_we    = 1'b1;
                mem_waddr = min_slot[AW-1:0];
                mem_wdata = r_val;
                n_min_cnt = r_min_cnt + CW'(1);
                n_min     = r_val;
                emit      = 1'b1;
            end
            min_stk_pkg::ST_POP_WAIT: begin
                // new top and minimum arrive from the store
                n_top      = r_rd_top;
                n_min      = r_rd_min;
                emit       = 1'b1;
                res_popped = r_popped;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        // capacity write empties both stacks
        if (i_cfg_we) begin
            n_main_cnt = '0;
            n_min_cnt  = '0;
        end
    end

    // read addresses follow the counts left by a pop
    always_comb begin
        logic [CW-1:0] top_idx;
        logic [CW-1:0] min_idx;
        top_idx     = n_main_cnt - CW'(1);
        min_idx     = cap_eff - n_min_cnt;
        rd_addr_top = top_idx[AW-1:0];
        rd_addr_min = min_idx[AW-1:0];
    end

    // store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_top <= mem[rd_addr_top];
        r_rd_min <= mem[rd_addr_min];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= min_stk_pkg::ST_IDLE;
            r_main_cnt <= '0;
            r_min_cnt  <= '0;
            r_cap      <= min_stk_pkg::CAP_W'(min_stk_pkg::DEPTH);
            o_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_main_cnt <= n_main_cnt;
            r_min_cnt  <= n_min_cnt;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            o_valid <= emit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_min    <= n_min;
        r_val    <= n_val;
        r_popped <= n_popped;
        if (emit) begin
            o_status       <= res_status;
            o_popped_value <= res_popped;
            o_top_value    <= (n_main_cnt != '0) ? n_top : '0;
            o_min_value    <= (n_min_cnt != '0) ? n_min : '0;
            o_is_empty     <= (n_main_cnt == '0);
        end
    end

`ifndef SYNTHESIS
    // both stacks fit in the store
    a_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_main_cnt} + {1'b0, r_min_cnt}) <= {1'b0, cap_eff})
        else $error("stacks exceed capacity");

    // every minimum entry shadows a main entry
    a_min_le_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min_cnt <= r_main_cnt)
        else $error("minimum stack deeper than main stack");

    // no result beat while a command is still at work
    a_no_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid)
        else $error("result beat during busy");

    // an accepted command either answers next cycle or keeps working
    a_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_valid != busy))
        else $error("accepted command lost");

    // a command in a busy state always answers as it returns to idle
    a_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("second cycle without result");
`endif

endmodule
